// ----- hdl/dnd_pkg.sv -----
package dnd_pkg;

   localparam int PACKET_BYTES     = 512;
   localparam int ADDR_W           = $clog2(PACKET_BYTES);
   localparam int IDX_W            = 14;
   localparam int HOP_LIMIT        = 16;
   localparam int HOP_W            = $clog2(HOP_LIMIT + 1);
   localparam int CHARS_PER_RESULT = 8;
   localparam int SLOT_W           = (CHARS_PER_RESULT > 1) ? $clog2(CHARS_PER_RESULT) : 1;
   localparam int MAX_RESULTS      = 32;
   localparam int RES_W            = $clog2(MAX_RESULTS);
   localparam int NAME_W           = 9;
   localparam int CHARS_W          = 64;
   localparam int COUNT_W          = 4;
   localparam int USED_W           = 10;
   localparam int LABEL_W          = 8;
   localparam int PTR_HI_W         = 6;

   localparam logic [NAME_W-1:0]  NAME_CAP      = 9'd256;
   localparam logic [LABEL_W-1:0] PTR_MARK      = 8'hC0;
   localparam logic [LABEL_W-1:0] PTR_HIGH_MASK = 8'h3F;
   localparam logic [LABEL_W-1:0] DOT_CHAR      = 8'h2E;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_TOO_LONG      = 2'd1,
      ST_HOP_LIMIT     = 2'd2,
      ST_OUT_OF_BUFFER = 2'd3
   } status_type;

   typedef enum logic {
      OP_STORE = 1'b0,
      OP_PARSE = 1'b1
   } opcode_type;

   typedef enum logic {
      RD_AT_INDEX = 1'b0,
      RD_AT_NEXT  = 1'b1
   } rd_sel_type;

   typedef struct packed {
      logic       store;
      logic       start;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       take_ptr;
      logic       load_ptr;
      logic       push_dot;
      logic       push_char;
      logic       load_count;
      logic       advance;
      logic       set_status;
      status_type status_code;
      logic       emit_final;
   } cmd_type;

   typedef struct packed {
      logic idx_oob;
      logic next_oob;
      logic byte_zero;
      logic byte_ptr;
      logic hop_full;
      logic name_nonzero;
      logic too_long;
      logic label_oob;
      logic push_fills;
      logic out_free;
      logic count_last;
   } stat_type;

endpackage

// ----- hdl/dnd_datapath.sv -----
module dnd_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  dnd_pkg::cmd_type             cmd,
   output dnd_pkg::stat_type            stat,
   input  logic [8:0]                   req_position,
   input  logic [7:0]                   req_byte_value,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [8:0]                   csr_max_name_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dnd_pkg::CHARS_W-1:0]  rsp_name_chars,
   output logic [dnd_pkg::COUNT_W-1:0]  rsp_char_count,
   output logic                         rsp_last,
   output logic [1:0]                   rsp_status,
   output logic [dnd_pkg::USED_W-1:0]   rsp_consumed_length
);

   logic [dnd_pkg::LABEL_W-1:0] mem [dnd_pkg::PACKET_BYTES];

   logic [dnd_pkg::LABEL_W-1:0]  rdata_ff;
   logic [dnd_pkg::IDX_W-1:0]    read_index_ff, read_index_in;
   logic [dnd_pkg::NAME_W-1:0]   name_length_ff, name_length_in;
   logic [dnd_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                         pointer_taken_ff, pointer_taken_in;
   logic [dnd_pkg::IDX_W-1:0]    saved_position_ff, saved_position_in;
   logic [dnd_pkg::HOP_W-1:0]    hop_count_ff, hop_count_in;
   logic [dnd_pkg::CHARS_W-1:0]  char_pack_ff, char_pack_in;
   logic [dnd_pkg::RES_W-1:0]    res_count_ff, res_count_in;
   logic [dnd_pkg::LABEL_W-1:0]  label_count_ff, label_count_in;
   logic [dnd_pkg::PTR_HI_W-1:0] ptr_hi_ff, ptr_hi_in;
   logic [8:0]                   start_pos_ff, start_pos_in;
   dnd_pkg::status_type          status_ff, status_in;
   logic [8:0]                   max_len_ff, max_len_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dnd_pkg::CHARS_W-1:0]  rsp_chars_ff, rsp_chars_in;
   logic [dnd_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                         rsp_last_ff, rsp_last_in;
   dnd_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [dnd_pkg::USED_W-1:0]   rsp_used_ff, rsp_used_in;

   logic [dnd_pkg::IDX_W-1:0]    rd_addr;
   logic [dnd_pkg::ADDR_W-1:0]   wr_addr;
   logic                         mem_we;
   logic                         push;
   logic [dnd_pkg::LABEL_W-1:0]  push_byte;
   logic [dnd_pkg::CHARS_W-1:0]  packed_chars;
   logic                         load_out;
   logic [8:0]                   eff_limit;
   logic [10:0]                  need_len;
   logic [dnd_pkg::IDX_W:0]      used_wide;

   assign csr_ready = 1'b1;
   assign max_len_in = (csr_valid && csr_ready) ? csr_max_name_length : max_len_ff;

   assign wr_addr = dnd_pkg::ADDR_W'(req_position);
   assign mem_we  = cmd.store && (32'(req_position) < dnd_pkg::PACKET_BYTES);
   assign rd_addr = (cmd.rd_sel == dnd_pkg::RD_AT_NEXT) ? read_index_ff + 1'b1 : read_index_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_byte_value;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr[dnd_pkg::ADDR_W-1:0]];
      end
   end

   assign eff_limit = (max_len_ff > dnd_pkg::NAME_CAP) ? dnd_pkg::NAME_CAP : max_len_ff;
   assign need_len  = {2'b0, name_length_ff} + 11'(name_length_ff != '0) + {3'b0, rdata_ff}
                      + 11'd1;

   always_comb begin
      stat.idx_oob      = 32'(read_index_ff) >= dnd_pkg::PACKET_BYTES;
      stat.next_oob     = 32'(read_index_ff) + 1 >= dnd_pkg::PACKET_BYTES;
      stat.byte_zero    = rdata_ff == '0;
      stat.byte_ptr     = (rdata_ff & dnd_pkg::PTR_MARK) == dnd_pkg::PTR_MARK;
      stat.hop_full     = 32'(hop_count_ff) >= dnd_pkg::HOP_LIMIT;
      stat.name_nonzero = name_length_ff != '0;
      stat.too_long     = need_len >= {2'b0, eff_limit};
      stat.label_oob    = 32'(read_index_ff) + 32'(rdata_ff) >= dnd_pkg::PACKET_BYTES;
      stat.push_fills   = 32'(slot_ff) == dnd_pkg::CHARS_PER_RESULT - 1;
      stat.out_free     = !rsp_valid_ff || rsp_ready;
      stat.count_last   = label_count_ff == 8'd1;
   end

   assign push      = cmd.push_dot || cmd.push_char;
   assign push_byte = cmd.push_dot ? dnd_pkg::DOT_CHAR : rdata_ff;

   always_comb begin
      packed_chars = char_pack_ff;
      packed_chars[8*slot_ff +: 8] = push_byte;
   end

   always_comb begin
      if (pointer_taken_ff) begin
         used_wide = {1'b0, saved_position_ff} + (dnd_pkg::IDX_W+1)'(2)
                     - (dnd_pkg::IDX_W+1)'(start_pos_ff);
      end else begin
         used_wide = {1'b0, read_index_ff} + (dnd_pkg::IDX_W+1)'(1)
                     - (dnd_pkg::IDX_W+1)'(start_pos_ff);
      end
   end

   always_comb begin
      read_index_in     = read_index_ff;
      name_length_in    = name_length_ff;
      slot_in           = slot_ff;
      pointer_taken_in  = pointer_taken_ff;
      saved_position_in = saved_position_ff;
      hop_count_in      = hop_count_ff;
      char_pack_in      = char_pack_ff;
      res_count_in      = res_count_ff;
      label_count_in    = label_count_ff;
      ptr_hi_in         = ptr_hi_ff;
      start_pos_in      = start_pos_ff;
      status_in         = status_ff;
      load_out          = 1'b0;
      rsp_chars_in      = rsp_chars_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_used_in       = rsp_used_ff;

      if (cmd.start) begin
         read_index_in     = dnd_pkg::IDX_W'(req_position);
         name_length_in    = '0;
         slot_in           = '0;
         pointer_taken_in  = 1'b0;
         saved_position_in = '0;
         hop_count_in      = '0;
         char_pack_in      = '0;
         res_count_in      = '0;
         start_pos_in      = req_position;
         status_in         = dnd_pkg::ST_OK;
      end

      if (cmd.take_ptr) begin
         if (!pointer_taken_ff) begin
            saved_position_in = read_index_ff;
            pointer_taken_in  = 1'b1;
         end
         hop_count_in = hop_count_ff + 1'b1;
         ptr_hi_in    = dnd_pkg::PTR_HI_W'(rdata_ff & dnd_pkg::PTR_HIGH_MASK);
      end

      if (cmd.load_ptr) begin
         read_index_in = dnd_pkg::IDX_W'({ptr_hi_ff, rdata_ff});
      end

      if (cmd.load_count) begin
         label_count_in = rdata_ff;
      end

      if (cmd.advance) begin
         read_index_in = read_index_ff + 1'b1;
      end

      if (cmd.push_char) begin
         label_count_in = label_count_ff - 1'b1;
      end

      if (push) begin
         name_length_in = name_length_ff + 1'b1;
         if (stat.push_fills) begin
            char_pack_in = '0;
            slot_in      = '0;
            if (32'(res_count_ff) < dnd_pkg::MAX_RESULTS - 1) begin
               res_count_in  = res_count_ff + 1'b1;
               load_out      = 1'b1;
               rsp_chars_in  = packed_chars;
               rsp_count_in  = dnd_pkg::COUNT_W'(dnd_pkg::CHARS_PER_RESULT);
               rsp_last_in   = 1'b0;
               rsp_status_in = dnd_pkg::ST_OK;
               rsp_used_in   = '0;
            end
         end else begin
            char_pack_in = packed_chars;
            slot_in      = slot_ff + 1'b1;
         end
      end

      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end

      if (cmd.emit_final) begin
         load_out      = 1'b1;
         rsp_last_in   = 1'b1;
         rsp_status_in = status_ff;
         if (status_ff == dnd_pkg::ST_OK) begin
            rsp_chars_in = char_pack_ff;
            rsp_count_in = dnd_pkg::COUNT_W'(slot_ff);
            rsp_used_in  = used_wide[dnd_pkg::USED_W-1:0];
         end else begin
            rsp_chars_in = '0;
            rsp_count_in = '0;
            rsp_used_in  = '0;
         end
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff     <= '0;
         name_length_ff    <= '0;
         slot_ff           <= '0;
         pointer_taken_ff  <= 1'b0;
         saved_position_ff <= '0;
         hop_count_ff      <= '0;
         char_pack_ff      <= '0;
         res_count_ff      <= '0;
         label_count_ff    <= '0;
         status_ff         <= dnd_pkg::ST_OK;
         max_len_ff        <= dnd_pkg::NAME_CAP;
         rsp_valid_ff      <= 1'b0;
      end else begin
         read_index_ff     <= read_index_in;
         name_length_ff    <= name_length_in;
         slot_ff           <= slot_in;
         pointer_taken_ff  <= pointer_taken_in;
         saved_position_ff <= saved_position_in;
         hop_count_ff      <= hop_count_in;
         char_pack_ff      <= char_pack_in;
         res_count_ff      <= res_count_in;
         label_count_ff    <= label_count_in;
         status_ff         <= status_in;
         max_len_ff        <= max_len_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_hi_ff     <= ptr_hi_in;
      start_pos_ff  <= start_pos_in;
      rsp_chars_ff  <= rsp_chars_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_name_chars      = rsp_chars_ff;
   assign rsp_char_count      = rsp_count_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_consumed_length = rsp_used_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      load_out |-> stat.out_free)
      else $error("result register overwritten while still pending");

   a_read_in_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> 32'(rd_addr) < dnd_pkg::PACKET_BYTES)
      else $error("packet read beyond the buffer");

   a_partial_results_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |->
         (32'(rsp_count_ff) == dnd_pkg::CHARS_PER_RESULT && rsp_status_ff == dnd_pkg::ST_OK))
      else $error("streamed result is not a full group of characters");

   a_error_result_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff && rsp_status_ff != dnd_pkg::ST_OK) |->
         (rsp_count_ff == '0 && rsp_name_chars == '0 && rsp_used_ff == '0))
      else $error("failed parse returned characters or a length");

endmodule

// ----- hdl/dnd_controller.sv -----
module dnd_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  dnd_pkg::stat_type   stat,
   output dnd_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_LEN   = 6'b000100,
      S_PTR   = 6'b001000,
      S_COPY  = 6'b010000,
      S_FINAL = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (dnd_pkg::opcode_type'(req_opcode) == dnd_pkg::OP_PARSE) begin
                  cmd.start = 1'b1;
                  state_in  = S_CHECK;
               end else begin
                  cmd.store = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (stat.idx_oob) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = dnd_pkg::ST_OUT_OF_BUFFER;
               state_in        = S_FINAL;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = dnd_pkg::RD_AT_INDEX;
               state_in   = S_LEN;
            end
         end
         S_LEN: begin
            if (stat.byte_zero) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = dnd_pkg::ST_OK;
               state_in        = S_FINAL;
            end else if (stat.byte_ptr) begin
               if (stat.next_oob) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = dnd_pkg::ST_OUT_OF_BUFFER;
                  state_in        = S_FINAL;
               end else if (stat.hop_full) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = dnd_pkg::ST_HOP_LIMIT;
                  state_in        = S_FINAL;
               end else begin
                  cmd.rd_en    = 1'b1;
                  cmd.rd_sel   = dnd_pkg::RD_AT_NEXT;
                  cmd.take_ptr = 1'b1;
                  state_in     = S_PTR;
               end
            end else if (!(stat.name_nonzero && stat.push_fills && !stat.out_free)) begin
               cmd.push_dot = stat.name_nonzero;
               if (stat.too_long) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = dnd_pkg::ST_TOO_LONG;
                  state_in        = S_FINAL;
               end else if (stat.label_oob) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = dnd_pkg::ST_OUT_OF_BUFFER;
                  state_in        = S_FINAL;
               end else begin
                  cmd.rd_en      = 1'b1;
                  cmd.rd_sel     = dnd_pkg::RD_AT_NEXT;
                  cmd.load_count = 1'b1;
                  cmd.advance    = 1'b1;
                  state_in       = S_COPY;
               end
            end
         end
         S_PTR: begin
            cmd.load_ptr = 1'b1;
            state_in     = S_CHECK;
         end
         S_COPY: begin
            if (!(stat.push_fills && !stat.out_free)) begin
               cmd.push_char = 1'b1;
               cmd.advance   = 1'b1;
               if (stat.count_last) begin
                  state_in = S_CHECK;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = dnd_pkg::RD_AT_NEXT;
               end
            end
         end
         S_FINAL: begin
            if (stat.out_free) begin
               cmd.emit_final = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/dns_name_decompressor.sv -----
// Store items write one packet byte each; they produce no result. A parse item walks the
// name at the given offset through the packet memory, which has one write port and one
// read port and whose read data is registered: each length byte, the closing zero byte
// included, is first addressed and then decoded, a pointer then has its second byte read
// and loaded as the new position, and the label characters are copied one by one; the item
// is accepted first and the final result handed over last, and a parse that fails ends
// at the byte that fails it. The walk pauses while a completed group of eight characters
// cannot enter the output register because the result held there has not been taken, and no
// new item is taken until the final result of a parse has been handed to the output register.
module dns_name_decompressor (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [8:0]                   req_position,
   input  logic [7:0]                   req_byte_value,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [8:0]                   csr_max_name_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dnd_pkg::CHARS_W-1:0]  rsp_name_chars,
   output logic [dnd_pkg::COUNT_W-1:0]  rsp_char_count,
   output logic                         rsp_last,
   output logic [1:0]                   rsp_status,
   output logic [dnd_pkg::USED_W-1:0]   rsp_consumed_length
);

   dnd_pkg::cmd_type  cmd;
   dnd_pkg::stat_type stat;

   dnd_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   dnd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_position        (req_position),
      .req_byte_value      (req_byte_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_name_length (csr_max_name_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_name_chars      (rsp_name_chars),
      .rsp_char_count      (rsp_char_count),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .rsp_consumed_length (rsp_consumed_length)
   );

endmodule

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PHASE_ITEMS   = 34;

   typedef struct packed {
      logic [dnd_pkg::CHARS_W-1:0] chars;
      logic [dnd_pkg::COUNT_W-1:0] count;
      logic                        last;
      dnd_pkg::status_type         status;
      logic [dnd_pkg::USED_W-1:0]  used;
   } name_piece_type;

   class name_scoreboard;
      logic [7:0]                  packet [dnd_pkg::PACKET_BYTES];
      logic [dnd_pkg::NAME_W-1:0]  name_limit = dnd_pkg::NAME_CAP;
      name_piece_type              pending_q [$];
      int                          error_count = 0;
      int unsigned                 chars_so_far;
      int unsigned                 pieces_out;
      logic [dnd_pkg::CHARS_W-1:0] pending_chars;

      task report(string msg);
         error_count++;
         $display("ERROR %0t: %s", $time, msg);
      endtask

      function void emit(logic [dnd_pkg::CHARS_W-1:0] chars, int unsigned count, logic last,
                         dnd_pkg::status_type status, int unsigned used);
         name_piece_type piece;
         piece.chars  = chars;
         piece.count  = dnd_pkg::COUNT_W'(count);
         piece.last   = last;
         piece.status = status;
         piece.used   = dnd_pkg::USED_W'(used);
         pending_q.push_back(piece);
      endfunction

      function void add_char(logic [7:0] c);
         pending_chars[8 * (chars_so_far % dnd_pkg::CHARS_PER_RESULT) +: 8] = c;
         chars_so_far++;
         if (chars_so_far % dnd_pkg::CHARS_PER_RESULT == 0) begin
            if (pieces_out < dnd_pkg::MAX_RESULTS - 1) begin
               emit(pending_chars, dnd_pkg::CHARS_PER_RESULT, 1'b0, dnd_pkg::ST_OK, 0);
               pieces_out++;
            end
            pending_chars = '0;
         end
      endfunction

      function void note_item(dnd_pkg::opcode_type op, logic [8:0] pos, logic [7:0] value);
         int unsigned         idx, saved, hops, lbl, used, k;
         int                  cap, budget;
         bit                  jumped;
         dnd_pkg::status_type st;
         if (op == dnd_pkg::OP_STORE) begin
            if (pos < dnd_pkg::PACKET_BYTES) begin
               packet[pos] = value;
            end
            return;
         end
         idx = pos;
         saved = 0;
         hops = 0;
         used = 0;
         jumped = 1'b0;
         st = dnd_pkg::ST_OK;
         chars_so_far = 0;
         pieces_out = 0;
         pending_chars = '0;
         cap = (name_limit > dnd_pkg::NAME_CAP) ? int'(dnd_pkg::NAME_CAP) : int'(name_limit);
         budget = cap - 1;
         forever begin
            if (idx >= dnd_pkg::PACKET_BYTES) begin
               st = dnd_pkg::ST_OUT_OF_BUFFER;
               break;
            end
            lbl = packet[idx];
            if (lbl == 0) begin
               used = jumped ? saved + 2 - pos : idx + 1 - pos;
               break;
            end
            if ((lbl & dnd_pkg::PTR_MARK) == dnd_pkg::PTR_MARK) begin
               if (idx + 1 >= dnd_pkg::PACKET_BYTES) begin
                  st = dnd_pkg::ST_OUT_OF_BUFFER;
                  break;
               end
               if (hops >= dnd_pkg::HOP_LIMIT) begin
                  st = dnd_pkg::ST_HOP_LIMIT;
                  break;
               end
               if (!jumped) begin
                  saved = idx;
                  jumped = 1'b1;
               end
               hops++;
               idx = ((lbl & dnd_pkg::PTR_HIGH_MASK) << 8) | packet[idx + 1];
               continue;
            end
            if (chars_so_far > 0) begin
               add_char(dnd_pkg::DOT_CHAR);
            end
            if (int'(chars_so_far) + int'(lbl) >= budget) begin
               st = dnd_pkg::ST_TOO_LONG;
               break;
            end
            if (idx + lbl >= dnd_pkg::PACKET_BYTES) begin
               st = dnd_pkg::ST_OUT_OF_BUFFER;
               break;
            end
            for (k = 1; k <= lbl; k++) begin
               add_char(packet[idx + k]);
            end
            idx += lbl + 1;
         end
         if (st == dnd_pkg::ST_OK) begin
            emit(pending_chars, chars_so_far % dnd_pkg::CHARS_PER_RESULT, 1'b1,
                 dnd_pkg::ST_OK, used);
         end else begin
            emit('0, 0, 1'b1, st, 0);
         end
      endfunction

      task check_result(logic [dnd_pkg::CHARS_W-1:0] chars,
                        logic [dnd_pkg::COUNT_W-1:0] count, logic last, logic [1:0] status,
                        logic [dnd_pkg::USED_W-1:0] used);
         name_piece_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result: chars %h count %0d last %b", chars, count,
                             last));
            return;
         end
         want = pending_q.pop_front();
         if (chars !== want.chars) begin
            report($sformatf("name_chars %h, expected %h", chars, want.chars));
         end
         if (count !== want.count) begin
            report($sformatf("char_count %0d, expected %0d", count, want.count));
         end
         if (last !== want.last) begin
            report($sformatf("last %b, expected %b", last, want.last));
         end
         if (status !== want.status) begin
            report($sformatf("status %0d, expected %0d", status, want.status));
         end
         if (used !== want.used) begin
            report($sformatf("consumed_length %0d, expected %0d", used, want.used));
         end
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_opcode;
   logic [8:0]                   req_position;
   logic [7:0]                   req_byte_value;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [8:0]                   csr_max_name_length;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [dnd_pkg::CHARS_W-1:0]  rsp_name_chars;
   logic [dnd_pkg::COUNT_W-1:0]  rsp_char_count;
   logic                         rsp_last;
   logic [1:0]                   rsp_status;
   logic [dnd_pkg::USED_W-1:0]   rsp_consumed_length;

   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;
   int unsigned         items_sent = 0;
   int                  quiet_cycles = 0;
   int unsigned         name_starts [$];
   name_scoreboard      sb;

   dns_name_decompressor dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_position        (req_position),
      .req_byte_value      (req_byte_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_name_length (csr_max_name_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_name_chars      (rsp_name_chars),
      .rsp_char_count      (rsp_char_count),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .rsp_consumed_length (rsp_consumed_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_item(dnd_pkg::opcode_type'(req_opcode), req_position, req_byte_value);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_name_chars, rsp_char_count, rsp_last, rsp_status,
                            rsp_consumed_length);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("dns_name_decompressor regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(dnd_pkg::opcode_type op, logic [8:0] pos, logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_position   <= pos;
      req_byte_value <= value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic store_byte(int unsigned pos, int unsigned value);
      send_item(dnd_pkg::OP_STORE, 9'(pos), 8'(value));
   endtask

   task automatic parse_name(int unsigned pos);
      send_item(dnd_pkg::OP_PARSE, 9'(pos), 8'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(int unsigned value);
      wait_idle();
      csr_valid           <= 1'b1;
      csr_max_name_length <= 9'(value);
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      sb.name_limit = 9'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(int send_pct, int recv_pct, int unsigned limit);
      int unsigned first, base, at, len, kind, pick, target;
      write_limit(limit);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first = items_sent;
      while (items_sent - first < PHASE_ITEMS) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            // A short label chain that ends in a terminator, a pointer to an
            // earlier name, or now and then nothing at all.
            base = $urandom_range(488);
            at = base;
            repeat ($urandom_range(1, 3)) begin
               len = $urandom_range(1, 6);
               store_byte(at, len);
               at++;
               repeat (len) begin
                  store_byte(at, $urandom_range(255));
                  at++;
               end
            end
            pick = $urandom_range(9);
            if (pick < 4 && name_starts.size() != 0) begin
               target = name_starts[$urandom_range(name_starts.size() - 1)];
               store_byte(at, dnd_pkg::PTR_MARK | (target >> 8));
               store_byte(at + 1, target & 8'hFF);
            end else if (pick < 9) begin
               store_byte(at, 0);
            end
            parse_name(base);
            name_starts.push_back(base);
            if (name_starts.size() > 8) begin
               void'(name_starts.pop_front());
            end
            if ($urandom_range(1) == 1) begin
               parse_name(name_starts[$urandom_range(name_starts.size() - 1)]);
            end
         end else if (kind < 85) begin
            parse_name($urandom_range(511));
         end else begin
            store_byte($urandom_range(511), $urandom_range(255));
         end
      end
   endtask

   initial begin
      int unsigned a;
      sb = new();
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_opcode          = 1'b0;
      req_position        = '0;
      req_byte_value      = '0;
      csr_valid           = 1'b0;
      csr_max_name_length = '0;
      rsp_ready           = 1'b0;
      send_idle_pct       = 16;
      recv_idle_pct       = 50;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      for (a = 0; a < dnd_pkg::PACKET_BYTES; a++) begin
         store_byte(a, $urandom_range(255));
      end

      store_byte(2, 2);
      store_byte(3, "a");
      store_byte(4, "b");
      store_byte(5, 1);
      store_byte(6, "c");
      store_byte(7, 0);
      parse_name(2);
      parse_name(7);
      store_byte(8, 1);
      store_byte(9, "x");
      store_byte(10, dnd_pkg::PTR_MARK);
      store_byte(11, 2);
      parse_name(8);
      store_byte(12, dnd_pkg::PTR_MARK);
      store_byte(13, 12);
      parse_name(12);
      store_byte(14, 8'h40);
      store_byte(79, 0);
      parse_name(14);
      store_byte(200, 8'hBF);
      store_byte(392, 8'h3E);
      store_byte(455, 0);
      parse_name(200);
      store_byte(505, 10);
      parse_name(505);
      store_byte(511, dnd_pkg::PTR_MARK | 8'h01);
      parse_name(511);
      write_limit(2);
      parse_name(2);
      write_limit(5);
      parse_name(8);
      write_limit(0);
      parse_name(7);
      parse_name(2);

      run_phase(16, 50, 256);
      run_phase(50, 16, $urandom_range(2, 24));
      run_phase(0, 0, 511);
      wait_idle();

      if (sb.error_count == 0 && sb.pending_q.size() == 0) begin
         $display("dns_name_decompressor regression: pass");
      end else begin
         $display("dns_name_decompressor regression: fail");
      end
      $finish;
   end

endmodule
